### hw/rtl/ubt_pkg.sv
// Shared constants, command and status codes, state type and RAM request
// struct for the unsorted byte table. No dependencies.
`default_nettype none

package ubt_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 8;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;
  localparam int FIDX_W = 6;
  localparam int FILL_W = 7;

  // common width for comparing a request position against counts
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int IN_W   = ((CMD_W + VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_W  = ((STAT_W + VAL_W + FIDX_W + FILL_W + 7) / 8) * 8;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_MOVE,
    S_POP_HEAD,
    S_SHIFT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

endpackage

`default_nettype wire

### hw/rtl/ubt_ram.sv
// Entry store of the unsorted byte table: one write port, one read port
// with registered read data. Depends on ubt_pkg.
`default_nettype none

module ubt_ram (
  input  wire logic                    clk,
  input  wire ubt_pkg::ram_req_t       req,
  output logic [ubt_pkg::VAL_W-1:0]    rd_data_r
);
  import ubt_pkg::*;

  logic [VAL_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem_r[req.rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/unsorted_byte_table.sv
// Top level of the unsorted byte table: request decode, sequencer and
// result register. Depends on ubt_pkg and ubt_ram.
//
// Usage: a request on the in_ channel carries cmd, item_value and position;
// each request gives exactly one result on the out_ channel with status,
// read_value, found_index and fill_count. Entries live in a RAM with one
// write port and one registered read port (one write, one read per cycle)
// that the sequencer walks one address per cycle.
// States from request to result:
//   append, write, unknown code, any miss found at decode: straight to S_EMIT
//   read: S_READ for the registered read, then S_EMIT
//   search: S_SCAN compares entries in turn (up to the fill count), then S_EMIT
//   delete: as search, plus S_MOVE to move the last entry into the hole
//   pop: S_POP_HEAD, then S_SHIFT once per shifted entry, then S_EMIT
// The single RAM read port limits every walk to one entry per cycle.
// in_tready is high only while the sequencer is idle; one request is
// worked on at a time.
// A finished result sits in the output register; the next request may be
// taken while it waits. If out_tready stays low, the sequencer holds its
// next result until the register frees up.
// Reset (rst_n low, synchronous) empties the table and drops any pending
// result. Entry contents are not cleared; only entries below the count are
// ever read.
`default_nettype none

module unsorted_byte_table (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // [2:0] cmd, [10:3] item_value, [18:11] position, upper bits zero
  input  wire logic [ubt_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // [1:0] status, [9:2] read_value, [15:10] found_index, [22:16] fill_count
  output logic [ubt_pkg::OUT_W-1:0]      out_tdata
);
  import ubt_pkg::*;

  // request fields
  logic [CMD_W-1:0] in_cmd;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  logic [CMP_W-1:0] pos_ext;
  logic [IDX_W-1:0] pos_idx;
  logic             in_fire;
  logic             pos_in_fill;
  logic             pos_in_depth;

  assign in_cmd   = in_tdata[CMD_W-1:0];
  assign in_value = in_tdata[CMD_W +: VAL_W];
  assign in_pos   = in_tdata[CMD_W + VAL_W +: POS_W];
  assign pos_ext  = CMP_W'(in_pos);
  assign pos_idx  = pos_ext[IDX_W-1:0];

  // sequencer state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    scan_r, scan_nxt;
  logic [CMD_W-1:0]    op_r;
  logic [VAL_W-1:0]    val_r;
  logic [STAT_W-1:0]   status_r, status_nxt;
  logic [VAL_W-1:0]    rval_r, rval_nxt;
  logic [FIDX_W-1:0]   fidx_r, fidx_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]    out_tdata_r, out_tdata_nxt;

  ram_req_t            ram_req;
  logic [VAL_W-1:0]    rd_data;

  logic                hit;
  logic                scan_last;
  logic                out_free;
  logic [IDX_W-1:0]    last_idx;
  logic [IDX_W-1:0]    scan_inc;

  ubt_ram u_ram (
    .clk       (clk),
    .req       (ram_req),
    .rd_data_r (rd_data)
  );

  assign in_tready    = (state_r == S_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign pos_in_fill  = (pos_ext < CMP_W'(count_r));
  assign pos_in_depth = (pos_ext < CMP_W'(DEPTH));

  // shared compare unit: the entry read last cycle against the search byte
  assign hit       = (rd_data == val_r);
  assign scan_last = ((CNT_W'(scan_r) + CNT_W'(1)) == count_r);
  assign scan_inc  = scan_r + IDX_W'(1);
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign out_free  = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          priority case (in_cmd)
            CMD_READ:   state_nxt = pos_in_fill ? S_READ : S_EMIT;
            CMD_SEARCH,
            CMD_DELETE: state_nxt = (count_r != '0) ? S_SCAN : S_EMIT;
            CMD_POP:    state_nxt = pos_in_fill ? S_POP_HEAD : S_EMIT;
            default:    state_nxt = S_EMIT;
          endcase
        end
      end
      S_READ: state_nxt = S_EMIT;
      S_SCAN: begin
        if (hit) begin
          state_nxt = ((op_r == CMD_DELETE) && !scan_last) ? S_MOVE : S_EMIT;
        end else if (scan_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_MOVE: state_nxt = S_EMIT;
      S_POP_HEAD,
      S_SHIFT: state_nxt = scan_last ? S_EMIT : S_SHIFT;
      S_EMIT: state_nxt = out_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    ram_req         = '0;
    ram_req.rd_addr = scan_r;
    count_nxt       = count_r;
    scan_nxt        = scan_r;
    status_nxt      = status_r;
    rval_nxt        = rval_r;
    fidx_nxt        = fidx_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    out_tdata_nxt   = out_tdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt = STAT_MISS;
          rval_nxt   = '0;
          fidx_nxt   = '0;
          priority case (in_cmd)
            CMD_APPEND: begin
              if (count_r == CNT_W'(DEPTH)) begin
                status_nxt = STAT_FULL;
              end else begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = IDX_W'(count_r);
                ram_req.wr_data = in_value;
                count_nxt       = count_r + CNT_W'(1);
                status_nxt      = STAT_OK;
              end
            end
            CMD_WRITE: begin
              if (pos_in_depth) begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = pos_idx;
                ram_req.wr_data = in_value;
                status_nxt      = STAT_OK;
              end
            end
            CMD_READ: begin
              ram_req.rd_addr = pos_idx;
            end
            CMD_SEARCH,
            CMD_DELETE: begin
              ram_req.rd_addr = '0;
              scan_nxt        = '0;
            end
            CMD_POP: begin
              ram_req.rd_addr = pos_idx;
              scan_nxt        = pos_idx;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        rval_nxt   = rd_data;
        status_nxt = STAT_OK;
      end
      S_SCAN: begin
        if (hit) begin
          if (op_r == CMD_SEARCH) begin
            fidx_nxt   = FIDX_W'(scan_r);
            status_nxt = STAT_OK;
          end else if (scan_last) begin
            // match is the last live entry: only the count drops
            count_nxt  = count_r - CNT_W'(1);
            status_nxt = STAT_OK;
          end else begin
            ram_req.rd_addr = last_idx;
          end
        end else if (!scan_last) begin
          ram_req.rd_addr = scan_inc;
          scan_nxt        = scan_inc;
        end
      end
      S_MOVE: begin
        // fill the hole with the last live entry
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = scan_r;
        ram_req.wr_data = rd_data;
        count_nxt       = count_r - CNT_W'(1);
        status_nxt      = STAT_OK;
      end
      S_POP_HEAD,
      S_SHIFT: begin
        if (state_r == S_POP_HEAD) begin
          rval_nxt = rd_data;
        end else begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = scan_r - IDX_W'(1);
          ram_req.wr_data = rd_data;
        end
        if (scan_last) begin
          count_nxt  = count_r - CNT_W'(1);
          status_nxt = STAT_OK;
        end else begin
          ram_req.rd_addr = scan_inc;
          scan_nxt        = scan_inc;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_W'({FILL_W'(count_r), fidx_r, rval_r, status_r});
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_cmd;
      val_r <= in_value;
    end
    scan_r      <= scan_nxt;
    status_r    <= status_nxt;
    rval_r      <= rval_nxt;
    fidx_r      <= fidx_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above table depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (count_r == $past(count_r) || count_r == $past(count_r) + CNT_W'(1) ||
         count_r == $past(count_r) - CNT_W'(1)))
    else $error("fill count moved by more than one");

  a_scan_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_SHIFT) |-> CNT_W'(scan_r) < count_r)
    else $error("walk index beyond live entries");
`endif

endmodule

`default_nettype wire
